// File: rtl/stv_pkg.sv
// Shared types and constants for the Smagorinsky turbulent viscosity pipeline.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps
package stv_pkg;
  localparam int DATA_W        = 32;
  localparam int OUT_W         = 48;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INV_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LSQ   = 2'd3;

  // Inverse spacings: element 0 is x, 1 is y, 2 is z.
  typedef logic [2:0][DATA_W-1:0] spacing_t;
endpackage

// File: rtl/stv_grad.sv
// Velocity differences and the nine scaled gradient magnitudes (two stages).
// Depends on stv_pkg.
`timescale 1ns / 1ps
module stv_grad #(
  parameter int FRAC_BITS = stv_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  logic                                   valid_i,
  input  logic signed [stv_pkg::DATA_W-1:0]      u_here,
  input  logic signed [stv_pkg::DATA_W-1:0]      u_right,
  input  logic signed [stv_pkg::DATA_W-1:0]      v_here,
  input  logic signed [stv_pkg::DATA_W-1:0]      v_top,
  input  logic signed [stv_pkg::DATA_W-1:0]      w_here,
  input  logic signed [stv_pkg::DATA_W-1:0]      w_front,
  input  logic        [stv_pkg::DATA_W-1:0]      density,
  input  stv_pkg::spacing_t                      inv,
  output logic                                   valid_o,
  output logic [8:0][2*stv_pkg::DATA_W-FRAC_BITS-1:0] g,
  output logic [2:0]                             sgn,
  output logic [stv_pkg::DATA_W-1:0]             rho_o
);
  import stv_pkg::*;

  localparam int GW = 2*DATA_W - FRAC_BITS;

  logic signed [DATA_W:0] diff [3];
  logic [DATA_W:0]        dmag [3];
  logic [2:0]             dneg;
  logic [DATA_W-1:0]      rho_a;
  logic                   va;
  logic [2*DATA_W:0]      prod [9];

  always_comb begin
    diff[0] = {u_right[DATA_W-1], u_right} - {u_here[DATA_W-1], u_here};
    diff[1] = {v_top[DATA_W-1], v_top} - {v_here[DATA_W-1], v_here};
    diff[2] = {w_front[DATA_W-1], w_front} - {w_here[DATA_W-1], w_here};
  end

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      for (int s = 0; s < 3; s++) begin
        prod[d*3+s] = (2*DATA_W+1)'(dmag[d]) * (2*DATA_W+1)'(inv[s]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va      <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv) begin
      va      <= valid_i;
      valid_o <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < 3; d++) begin
        dneg[d] <= diff[d][DATA_W];
        dmag[d] <= diff[d][DATA_W] ? $unsigned(-diff[d]) : $unsigned(diff[d]);
      end
      rho_a <= density;
      for (int i = 0; i < 9; i++) begin
        g[i] <= prod[i][FRAC_BITS +: GW];
      end
      sgn   <= dneg;
      rho_o <= rho_a;
    end
  end
endmodule

// File: rtl/stv_square.sv
// Strain terms, their squares from split partial products, and the sum S2.
// Five stages. Depends on stv_pkg.
`timescale 1ns / 1ps
module stv_square #(
  parameter int FRAC_BITS = stv_pkg::FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        adv,
  input  logic                                        valid_i,
  input  logic [8:0][2*stv_pkg::DATA_W-FRAC_BITS-1:0] g,
  input  logic [2:0]                                  sgn,
  input  logic [stv_pkg::DATA_W-1:0]                  rho_i,
  output logic                                        valid_o,
  output logic [2*(2*stv_pkg::DATA_W-FRAC_BITS)+4:0]  rad,
  output logic [stv_pkg::DATA_W-1:0]                  rho_o
);
  import stv_pkg::*;

  localparam int GW  = 2*DATA_W - FRAC_BITS;
  localparam int MW  = GW + 1;
  localparam int H   = (MW + 1) / 2;
  localparam int HW  = MW - H;
  localparam int SQW = 2*MW;
  localparam int SW  = 2*MW + 3;

  function automatic logic [MW-1:0] cross_mag(input logic [GW-1:0] a, input logic sa,
                                              input logic [GW-1:0] b, input logic sb);
    logic [MW-1:0] ea;
    logic [MW-1:0] eb;
    ea = MW'(a);
    eb = MW'(b);
    if (sa == sb) cross_mag = ea + eb;
    else if (ea >= eb) cross_mag = ea - eb;
    else cross_mag = eb - ea;
  endfunction

  logic [MW-1:0]     m [6];
  logic [2*HW-1:0]   pp_hh [6];
  logic [HW+H-1:0]   pp_hl [6];
  logic [2*H-1:0]    pp_ll [6];
  logic [SQW-1:0]    sq [6];
  logic [SQW+1:0]    sum_d;
  logic [SQW+1:0]    sum_c;
  logic [DATA_W-1:0] rho_c, rho_d, rho_e, rho_f;
  logic [3:0]        v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v       <= '0;
      valid_o <= 1'b0;
    end else if (adv) begin
      v       <= {v[2:0], valid_i};
      valid_o <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m[0] <= MW'(g[0]);
      m[1] <= MW'(g[4]);
      m[2] <= MW'(g[8]);
      m[3] <= cross_mag(g[1], sgn[0], g[3], sgn[1]);
      m[4] <= cross_mag(g[2], sgn[0], g[6], sgn[2]);
      m[5] <= cross_mag(g[5], sgn[1], g[7], sgn[2]);
      for (int k = 0; k < 6; k++) begin
        pp_hh[k] <= (2*HW)'(m[k][MW-1:H]) * (2*HW)'(m[k][MW-1:H]);
        pp_hl[k] <= (HW+H)'(m[k][MW-1:H]) * (HW+H)'(m[k][H-1:0]);
        pp_ll[k] <= (2*H)'(m[k][H-1:0]) * (2*H)'(m[k][H-1:0]);
        sq[k]    <= (SQW'(pp_hh[k]) << (2*H)) + (SQW'(pp_hl[k]) << (H+1))
                    + SQW'(pp_ll[k]);
      end
      sum_d <= (SQW+2)'(sq[0]) + (SQW+2)'(sq[1]) + (SQW+2)'(sq[2]);
      sum_c <= (SQW+2)'(sq[3]) + (SQW+2)'(sq[4]) + (SQW+2)'(sq[5]);
      rad   <= (SW'(sum_d) << 1) + SW'(sum_c);
      rho_c <= rho_i;
      rho_d <= rho_c;
      rho_e <= rho_d;
      rho_f <= rho_e;
      rho_o <= rho_f;
    end
  end
endmodule

// File: rtl/stv_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on stv_pkg.
`timescale 1ns / 1ps
module stv_isqrt #(
  parameter int FRAC_BITS = stv_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       adv,
  input  logic                                       valid_i,
  input  logic [2*(2*stv_pkg::DATA_W-FRAC_BITS)+4:0] rad,
  input  logic [stv_pkg::DATA_W-1:0]                 rho_i,
  output logic                                       valid_o,
  output logic [2*stv_pkg::DATA_W-FRAC_BITS+2:0]     root,
  output logic [stv_pkg::DATA_W-1:0]                 rho_o
);
  import stv_pkg::*;

  localparam int QW = 2*DATA_W - FRAC_BITS + 3;
  localparam int RW = 2*QW;

  logic [RW-1:0]     rem_q  [QW];
  logic [QW-1:0]     root_q [QW];
  logic [DATA_W-1:0] rho_q  [QW];
  logic              v_q    [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [RW-1:0]     rem_in;
    logic [QW-1:0]     root_in;
    logic [DATA_W-1:0] rho_in;
    logic              v_in;
    logic [RW-1:0]     trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in  = RW'(rad);
      assign root_in = '0;
      assign rho_in  = rho_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rho_in  = rho_q[k-1];
      assign v_in    = v_q[k-1];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial = (RW'(root_in) << (B+1)) | (RW'(1) << (2*B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) v_q[k] <= 1'b0;
      else if (adv) v_q[k] <= v_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k]  <= take ? rem_in - trial : rem_in;
        root_q[k] <= take ? root_in | (QW'(1) << B) : root_in;
        rho_q[k]  <= rho_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign root    = root_q[QW-1];
  assign rho_o   = rho_q[QW-1];
endmodule

// File: rtl/stv_scale.sv
// Density times length scale times root, split multiply, rescale and clamp.
// Three stages, last one is the output register. Depends on stv_pkg.
`timescale 1ns / 1ps
module stv_scale #(
  parameter int FRAC_BITS = stv_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  logic                                   valid_i,
  input  logic [2*stv_pkg::DATA_W-FRAC_BITS+2:0] root,
  input  logic [stv_pkg::DATA_W-1:0]             rho_i,
  input  logic [stv_pkg::DATA_W-1:0]             lsq,
  output logic                                   valid_o,
  output logic [stv_pkg::OUT_W-1:0]              val,
  output logic                                   sat
);
  import stv_pkg::*;

  localparam int QW  = 2*DATA_W - FRAC_BITS + 3;
  localparam int QH  = (QW + 1) / 2;
  localparam int QHW = QW - QH;
  localparam int PW  = 2*DATA_W + QW;
  localparam int LO  = 2*FRAC_BITS;

  logic [2*DATA_W-1:0]   p1;
  logic [QW-1:0]         q1;
  logic [DATA_W+QH-1:0]  pp0, pp2;
  logic [DATA_W+QHW-1:0] pp1, pp3;
  logic [PW-1:0]         prod;
  logic [1:0]            v;

  assign prod = PW'(pp0) + (PW'(pp1) << QH) + (PW'(pp2) << DATA_W)
                + (PW'(pp3) << (DATA_W + QH));

  always_ff @(posedge clk) begin
    if (rst) begin
      v       <= '0;
      valid_o <= 1'b0;
    end else if (adv) begin
      v       <= {v[0], valid_i};
      valid_o <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1  <= (2*DATA_W)'(rho_i) * (2*DATA_W)'(lsq);
      q1  <= root;
      pp0 <= (DATA_W+QH)'(p1[DATA_W-1:0]) * (DATA_W+QH)'(q1[QH-1:0]);
      pp1 <= (DATA_W+QHW)'(p1[DATA_W-1:0]) * (DATA_W+QHW)'(q1[QW-1:QH]);
      pp2 <= (DATA_W+QH)'(p1[2*DATA_W-1:DATA_W]) * (DATA_W+QH)'(q1[QH-1:0]);
      pp3 <= (DATA_W+QHW)'(p1[2*DATA_W-1:DATA_W]) * (DATA_W+QHW)'(q1[QW-1:QH]);
      // clamp when anything sits above the 48 result bits
      sat <= |prod[PW-1:OUT_W+LO];
      val <= (|prod[PW-1:OUT_W+LO]) ? '1 : prod[LO +: OUT_W];
    end
  end
endmodule

// File: rtl/smagorinsky_turbulent_viscosity.sv
// Smagorinsky eddy viscosity per grid cell, streaming pipeline.
// Channels: input transaction carries six face velocities and density (in_valid /
// in_ready); output transaction carries eddy_visc and saturated
// (out_valid / out_ready). Configuration: cfg_we writes cfg_data to register
// cfg_index (0..2 inverse spacings, 3 squared length scale), write only when idle.
// Throughput: one transaction per cycle while the receiver does not stall. The
// square root produces one result bit per stage.
// Reset clears all valid bits and sets every configuration register to 1.0.
// When the receiver stalls, the whole pipe holds and in_ready drops; nothing is
// lost or repeated. A new transaction is taken in the same cycle that the
// waiting result is taken.
// Depends on stv_pkg, stv_grad, stv_square, stv_isqrt, stv_scale.
`timescale 1ns / 1ps
module smagorinsky_turbulent_viscosity #(
  parameter int FRAC_BITS = stv_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [stv_pkg::DATA_W-1:0] u_here,
  input  logic signed [stv_pkg::DATA_W-1:0] u_right,
  input  logic signed [stv_pkg::DATA_W-1:0] v_here,
  input  logic signed [stv_pkg::DATA_W-1:0] v_top,
  input  logic signed [stv_pkg::DATA_W-1:0] w_here,
  input  logic signed [stv_pkg::DATA_W-1:0] w_front,
  input  logic        [stv_pkg::DATA_W-1:0] density,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [stv_pkg::OUT_W-1:0]         eddy_visc,
  output logic                              saturated,
  input  logic                              cfg_we,
  input  logic [stv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stv_pkg::DATA_W-1:0]        cfg_data
);
  import stv_pkg::*;

  localparam int GW  = 2*DATA_W - FRAC_BITS;
  localparam int SW  = 2*GW + 5;
  localparam int QW  = GW + 3;
  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  logic [DATA_W-1:0] inv_x, inv_y, inv_z, lsq;
  spacing_t          inv;
  logic              adv;

  logic                v_g, v_s, v_r;
  logic [8:0][GW-1:0]  g;
  logic [2:0]          sgn;
  logic [DATA_W-1:0]   rho_g, rho_s, rho_r;
  logic [SW-1:0]       rad;
  logic [QW-1:0]       root;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_x <= ONE;
      inv_y <= ONE;
      inv_z <= ONE;
      lsq   <= ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_X: inv_x <= cfg_data;
        REG_INV_Y: inv_y <= cfg_data;
        REG_INV_Z: inv_z <= cfg_data;
        REG_LSQ:   lsq   <= cfg_data;
      endcase
    end
  end

  assign inv      = {inv_z, inv_y, inv_x};
  // advance the whole pipe unless the output register holds an untaken result
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  stv_grad #(.FRAC_BITS(FRAC_BITS)) u_grad (
    .clk, .rst, .adv, .valid_i(in_valid),
    .u_here, .u_right, .v_here, .v_top, .w_here, .w_front, .density,
    .inv, .valid_o(v_g), .g, .sgn, .rho_o(rho_g)
  );

  stv_square #(.FRAC_BITS(FRAC_BITS)) u_square (
    .clk, .rst, .adv, .valid_i(v_g), .g, .sgn, .rho_i(rho_g),
    .valid_o(v_s), .rad, .rho_o(rho_s)
  );

  stv_isqrt #(.FRAC_BITS(FRAC_BITS)) u_isqrt (
    .clk, .rst, .adv, .valid_i(v_s), .rad, .rho_i(rho_s),
    .valid_o(v_r), .root, .rho_o(rho_r)
  );

  stv_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk, .rst, .adv, .valid_i(v_r), .root, .rho_i(rho_r), .lsq,
    .valid_o(out_valid), .val(eddy_visc), .sat(saturated)
  );

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> eddy_visc == {OUT_W{1'b1}})
    else $error("saturated result is not the maximum");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented right after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("transaction taken while the pipe is stalled");
endmodule
